[hdl/euler_characteristic_eigenvectors_core_macros.svh]
// Assertion helpers shared by the core. Each one checks on the rising clock
// edge and stays quiet while the asynchronous reset is asserted.
`ifndef EULER_CHARACTERISTIC_EIGENVECTORS_CORE_MACROS_SVH
`define EULER_CHARACTERISTIC_EIGENVECTORS_CORE_MACROS_SVH

// A condition that must hold at every edge.
`define ECEV_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define ECEV_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hdl/ecev_pkg.sv]
package ecev_pkg;

	// Q16.16 constants.
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// Reset value of gamma (1.4) and the unit value subtracted to form gamma - 1.
	localparam logic [17:0] GAMMA_RESET = 18'd91750;
	localparam logic [17:0] GAMMA_UNIT  = 18'd65536;

	// Every divider and the square root produce this many result bits.
	localparam int QUOT_W = 31;
	// The sound speed never needs more than this many bits.
	localparam int C_W = 24;
	// Default number of division or root steps done per pipeline stage.
	localparam int DEF_STAGE_STEPS = 4;

	// Row codes.
	localparam logic [1:0] ROW_TOP = 2'd0;
	localparam logic [1:0] ROW_MID = 2'd1;
	localparam logic [1:0] ROW_BOT = 2'd2;

	typedef struct packed {
		logic signed [31:0] density;
		logic signed [31:0] velocity_x;
		logic signed [31:0] pressure;
	} item_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] right_col0;
		logic signed [31:0] right_col1;
		logic signed [31:0] right_col2;
		logic signed [31:0] left_col0;
		logic signed [31:0] left_col1;
		logic signed [31:0] left_col2;
		logic               last_row;
	} result_t;

	// Data riding alongside the squared sound speed division.
	typedef struct packed {
		logic signed [31:0] u;
		logic signed [31:0] uu;
		logic               pneg;
	} side_a_t;

	// Data riding alongside the square root.
	typedef struct packed {
		logic signed [31:0] u;
		logic signed [31:0] uu;
	} side_b_t;

	// Data riding alongside the divisions by the sound speed.
	typedef struct packed {
		logic signed [31:0] u;
		logic [C_W-1:0]     c;
		logic signed [31:0] h;
		logic signed [31:0] uc;
		logic signed [31:0] b1;
		logic signed [31:0] b2;
		logic signed [31:0] b1u;
		logic signed [31:0] uuh;
	} side_c_t;

	function automatic logic [31:0] abs32(input logic signed [31:0] a);
		return a[31] ? 32'(-a) : 32'(a);
	endfunction

	// Signed value from a magnitude, saturated to Q16.16.
	function automatic logic signed [31:0] sat_mag(input logic [47:0] m, input logic neg);
		if (neg) begin
			return (m > 48'h0000_8000_0000) ? Q_MIN : $signed(-m[31:0]);
		end
		return (m > 48'h0000_7FFF_FFFF) ? Q_MAX : $signed(m[31:0]);
	endfunction

	// Product of two magnitudes with the sign applied, truncated and saturated.
	function automatic logic signed [31:0] mulsat(input logic [31:0] a, input logic [31:0] b,
			input logic neg);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return sat_mag(p[63:16], neg);
	endfunction

	// Quotient with an overflow flag turned into a saturated signed value.
	function automatic logic signed [31:0] sat_q(input logic ovf, input logic [QUOT_W-1:0] q,
			input logic neg);
		if (ovf) begin
			return neg ? Q_MIN : Q_MAX;
		end
		return neg ? $signed(-{1'b0, q}) : $signed({1'b0, q});
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? Q_MIN : Q_MAX;
		end
		return $signed(s[31:0]);
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [32:0] s;
		s = {a[31], a} - {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? Q_MIN : Q_MAX;
		end
		return $signed(s[31:0]);
	endfunction

	// Halving truncates the magnitude toward zero.
	function automatic logic signed [31:0] qhalf(input logic signed [31:0] a);
		logic [31:0] m;
		m = abs32(a) >> 1;
		return a[31] ? $signed(-m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
		return (a == Q_MIN) ? Q_MAX : -a;
	endfunction

endpackage

[hdl/ecev_div.sv]
// Pipelined restoring divider. The high part of the numerator is checked
// against the divisor up front; when it is not smaller the quotient does not
// fit and the overflow flag is raised instead.
module ecev_div #(
	parameter int NW   = 48,
	parameter int DW   = 24,
	parameter int QW   = 31,
	parameter int STEP = 4,
	parameter int SW   = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic          out_ovf,
	output logic [QW-1:0] quot,
	output logic [SW-1:0] side_out
);

	localparam int NS = (QW + STEP - 1) / STEP;
	localparam int HW = NW - QW;
	localparam int CW = ((HW > DW) ? HW : DW) + 1;

	logic [CW-1:0] hi_c;
	logic [CW-1:0] den_c;
	logic          ovf_in;
	logic [DW-1:0] rem_in;

	logic          vld_s  [NS];
	logic          ovf_s  [NS];
	logic [DW-1:0] rem_s  [NS];
	logic [DW-1:0] den_s  [NS];
	logic [QW-1:0] lq_s   [NS];
	logic [SW-1:0] side_s [NS];

	assign hi_c   = CW'(num[NW-1:QW]);
	assign den_c  = CW'(den);
	assign ovf_in = (hi_c >= den_c);
	assign rem_in = ovf_in ? '0 : DW'(hi_c);

	function automatic void div_steps(input logic [DW-1:0] r_i, input logic [QW-1:0] l_i,
			input logic [DW-1:0] d, input int base,
			output logic [DW-1:0] r_o, output logic [QW-1:0] l_o);
		logic [DW:0]   t;
		logic [DW-1:0] r;
		logic [QW-1:0] l;
		r = r_i;
		l = l_i;
		for (int k = 0; k < STEP; k++) begin
			if (base + k < QW) begin
				t = {r, l[QW-1]};
				if (t >= {1'b0, d}) begin
					t = t - {1'b0, d};
					l = {l[QW-2:0], 1'b1};
				end else begin
					l = {l[QW-2:0], 1'b0};
				end
				r = t[DW-1:0];
			end
		end
		r_o = r;
		l_o = l;
	endfunction

	for (genvar s = 0; s < NS; s++) begin : g_stage
		logic          v_prev;
		logic          o_prev;
		logic [DW-1:0] r_prev;
		logic [DW-1:0] d_prev;
		logic [QW-1:0] l_prev;
		logic [SW-1:0] sd_prev;
		logic [DW-1:0] r_nxt;
		logic [QW-1:0] l_nxt;

		if (s == 0) begin : g_first
			assign v_prev  = in_valid;
			assign o_prev  = ovf_in;
			assign r_prev  = rem_in;
			assign d_prev  = den;
			assign l_prev  = num[QW-1:0];
			assign sd_prev = side_in;
		end else begin : g_next
			assign v_prev  = vld_s[s-1];
			assign o_prev  = ovf_s[s-1];
			assign r_prev  = rem_s[s-1];
			assign d_prev  = den_s[s-1];
			assign l_prev  = lq_s[s-1];
			assign sd_prev = side_s[s-1];
		end

		always_comb begin
			div_steps(r_prev, l_prev, d_prev, s * STEP, r_nxt, l_nxt);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (en) begin
				vld_s[s] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ovf_s[s]  <= o_prev;
				rem_s[s]  <= r_nxt;
				den_s[s]  <= d_prev;
				lq_s[s]   <= l_nxt;
				side_s[s] <= sd_prev;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_ovf   = ovf_s[NS-1];
	assign quot      = lq_s[NS-1];
	assign side_out  = side_s[NS-1];

endmodule

[hdl/ecev_sqrt.sv]
// Pipelined floor square root, one result bit per step, two operand bits
// consumed per step.
module ecev_sqrt #(
	parameter int RW   = 31,
	parameter int STEP = 4,
	parameter int SW   = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] operand,
	input  logic [SW-1:0]   side_in,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   side_out
);

	localparam int NS = (RW + STEP - 1) / STEP;

	logic            vld_s  [NS];
	logic [RW+1:0]   rem_s  [NS];
	logic [RW-1:0]   root_s [NS];
	logic [2*RW-1:0] op_s   [NS];
	logic [SW-1:0]   side_s [NS];

	function automatic void root_steps(input logic [RW+1:0] r_i, input logic [RW-1:0] q_i,
			input logic [2*RW-1:0] o_i, input int base,
			output logic [RW+1:0] r_o, output logic [RW-1:0] q_o,
			output logic [2*RW-1:0] o_o);
		logic [RW+3:0]   t;
		logic [RW+3:0]   trial;
		logic [RW+1:0]   r;
		logic [RW-1:0]   q;
		logic [2*RW-1:0] o;
		r = r_i;
		q = q_i;
		o = o_i;
		for (int k = 0; k < STEP; k++) begin
			if (base + k < RW) begin
				t     = {r, o[2*RW-1:2*RW-2]};
				trial = {2'b00, q, 2'b01};
				if (t >= trial) begin
					t = t - trial;
					q = {q[RW-2:0], 1'b1};
				end else begin
					q = {q[RW-2:0], 1'b0};
				end
				r = t[RW+1:0];
				o = {o[2*RW-3:0], 2'b00};
			end
		end
		r_o = r;
		q_o = q;
		o_o = o;
	endfunction

	for (genvar s = 0; s < NS; s++) begin : g_stage
		logic            v_prev;
		logic [RW+1:0]   r_prev;
		logic [RW-1:0]   q_prev;
		logic [2*RW-1:0] o_prev;
		logic [SW-1:0]   sd_prev;
		logic [RW+1:0]   r_nxt;
		logic [RW-1:0]   q_nxt;
		logic [2*RW-1:0] o_nxt;

		if (s == 0) begin : g_first
			assign v_prev  = in_valid;
			assign r_prev  = '0;
			assign q_prev  = '0;
			assign o_prev  = operand;
			assign sd_prev = side_in;
		end else begin : g_next
			assign v_prev  = vld_s[s-1];
			assign r_prev  = rem_s[s-1];
			assign q_prev  = root_s[s-1];
			assign o_prev  = op_s[s-1];
			assign sd_prev = side_s[s-1];
		end

		always_comb begin
			root_steps(r_prev, q_prev, o_prev, s * STEP, r_nxt, q_nxt, o_nxt);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (en) begin
				vld_s[s] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s]  <= r_nxt;
				root_s[s] <= q_nxt;
				op_s[s]   <= o_nxt;
				side_s[s] <= sd_prev;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign root      = root_s[NS-1];
	assign side_out  = side_s[NS-1];

endmodule

[hdl/euler_characteristic_eigenvectors_core.sv]
//  channel   direction  handshake            word
//  item      in         item_valid/stall     density, velocity_x, pressure
//  result    out        result_valid/stall   one row of R and of L
//  cfg       in         cfg_valid/ready      heat_capacity_ratio
//
//  Every word in gives three result words, rows 0, 1 and 2; a new word can
//  enter each cycle while item_stall is low, and the single result port,
//  handing out one row at a time, sets the sustained rate. STAGE_STEPS is
//  the number of divider and root steps done per stage. Reset clears all
//  valid bits and loads gamma = 1.4. A stall on the result side freezes the
//  whole pipeline as soon as a finished word is waiting.
`include "euler_characteristic_eigenvectors_core_macros.svh"

module euler_characteristic_eigenvectors_core
	import ecev_pkg::*;
#(
	parameter int STAGE_STEPS = DEF_STAGE_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [17:0] cfg_data
);

	// The gamma register. Writes must only arrive while the core is idle; the
	// block itself does not enforce this, and the pipeline reads it directly.
	logic [17:0] gamma_q;
	logic [17:0] gm1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gamma_q <= cfg_data;
		end
	end

	// gamma - 1, with one LSB taken when gamma is not above one.
	assign gm1 = (gamma_q > GAMMA_UNIT) ? (gamma_q - GAMMA_UNIT) : 18'd1;

	// The whole pipeline moves as one; it only halts when a finished word
	// cannot be handed to the row buffer.
	logic adv;
	logic buf_free;
	logic load;
	logic fire;

	// Stage 1: register the word, floor the density, split the pressure sign.
	logic               v_s1;
	logic [30:0]        rho_s1;
	logic [31:0]        pmag_s1;
	logic               pneg_s1;
	logic signed [31:0] u_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rho_s1  <= (item.density < 32'sd1) ? 31'd1 : item.density[30:0];
			pmag_s1 <= abs32(item.pressure);
			pneg_s1 <= item.pressure[31];
			u_s1    <= item.velocity_x;
		end
	end

	// Stage 2: gamma * |p| and u * u.
	logic               v_s2;
	logic [49:0]        prod_s2;
	logic [30:0]        rho_s2;
	logic               pneg_s2;
	logic signed [31:0] u_s2;
	logic signed [31:0] uu_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= {18'd0, pmag_s1} * {32'd0, gamma_q};
			rho_s2  <= rho_s1;
			pneg_s2 <= pneg_s1;
			u_s2    <= u_s1;
			uu_s2   <= mulsat(abs32(u_s1), abs32(u_s1), 1'b0);
		end
	end

	// Squared sound speed before clamping: gamma * p / rho.
	side_a_t         side_a_in;
	side_a_t         side_a_out;
	logic            diva_vld;
	logic            diva_ovf;
	logic [QUOT_W-1:0] diva_q;

	assign side_a_in = '{u: u_s2, uu: uu_s2, pneg: pneg_s2};

	ecev_div #(
		.NW(50), .DW(31), .QW(QUOT_W), .STEP(STAGE_STEPS), .SW($bits(side_a_t))
	) u_div_c2 (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s2), .num(prod_s2), .den(rho_s2), .side_in(side_a_in),
		.out_valid(diva_vld), .out_ovf(diva_ovf), .quot(diva_q), .side_out(side_a_out)
	);

	// Stage 3: clamp c2 to at least one LSB; negative pressure gives one LSB.
	logic               v_s3;
	logic [30:0]        c2_s3;
	logic signed [31:0] u_s3;
	logic signed [31:0] uu_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= diva_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_a_out.pneg || (!diva_ovf && diva_q == '0)) begin
				c2_s3 <= 31'd1;
			end else if (diva_ovf) begin
				c2_s3 <= 31'h7FFF_FFFF;
			end else begin
				c2_s3 <= diva_q;
			end
			u_s3  <= side_a_out.u;
			uu_s3 <= side_a_out.uu;
		end
	end

	// Three units in step: c = sqrt(c2), c2/(gamma-1) and b1 = (gamma-1)/c2.
	side_b_t           side_b_in;
	side_b_t           side_b_out;
	logic              sq_vld;
	logic [QUOT_W-1:0] sq_root;
	logic              divb_vld;
	logic              divb_ovf;
	logic [QUOT_W-1:0] divb_q;
	logic              divc_vld;
	logic              divc_ovf;
	logic [QUOT_W-1:0] divc_q;

	assign side_b_in = '{u: u_s3, uu: uu_s3};

	ecev_sqrt #(
		.RW(QUOT_W), .STEP(STAGE_STEPS), .SW($bits(side_b_t))
	) u_sqrt_c (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s3), .operand({15'd0, c2_s3, 16'd0}), .side_in(side_b_in),
		.out_valid(sq_vld), .root(sq_root), .side_out(side_b_out)
	);

	ecev_div #(
		.NW(47), .DW(18), .QW(QUOT_W), .STEP(STAGE_STEPS), .SW(1)
	) u_div_h (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s3), .num({c2_s3, 16'd0}), .den(gm1), .side_in(1'b0),
		.out_valid(divb_vld), .out_ovf(divb_ovf), .quot(divb_q), .side_out()
	);

	ecev_div #(
		.NW(34), .DW(31), .QW(QUOT_W), .STEP(STAGE_STEPS), .SW(1)
	) u_div_b1 (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s3), .num({gm1, 16'd0}), .den(c2_s3), .side_in(1'b0),
		.out_valid(divc_vld), .out_ovf(divc_ovf), .quot(divc_q), .side_out()
	);

	// Stage 4: enthalpy H, u*c, b2 = half(b1*u*u) and b1*u.
	logic               v_s4;
	side_c_t            side_c_s4;
	logic signed [31:0] b1_c;

	assign b1_c = sat_q(divc_ovf, divc_q, 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_c_s4.u   <= side_b_out.u;
			side_c_s4.c   <= sq_root[C_W-1:0];
			side_c_s4.h   <= qadd(sat_q(divb_ovf, divb_q, 1'b0), qhalf(side_b_out.uu));
			side_c_s4.uc  <= mulsat(abs32(side_b_out.u), {8'd0, sq_root[C_W-1:0]},
				side_b_out.u[31]);
			side_c_s4.b1  <= b1_c;
			side_c_s4.b2  <= qhalf(mulsat(32'(b1_c), 32'(side_b_out.uu), 1'b0));
			side_c_s4.b1u <= mulsat(32'(b1_c), abs32(side_b_out.u), side_b_out.u[31]);
			side_c_s4.uuh <= qhalf(side_b_out.uu);
		end
	end

	// u/c and 1/c, again two units in step.
	side_c_t           side_c_out;
	logic              divd_vld;
	logic              divd_ovf;
	logic [QUOT_W-1:0] divd_q;
	logic              dive_vld;
	logic              dive_ovf;
	logic [QUOT_W-1:0] dive_q;

	ecev_div #(
		.NW(48), .DW(C_W), .QW(QUOT_W), .STEP(STAGE_STEPS), .SW($bits(side_c_t))
	) u_div_uoc (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s4), .num({abs32(side_c_s4.u), 16'd0}), .den(side_c_s4.c),
		.side_in(side_c_s4),
		.out_valid(divd_vld), .out_ovf(divd_ovf), .quot(divd_q), .side_out(side_c_out)
	);

	ecev_div #(
		.NW(33), .DW(C_W), .QW(QUOT_W), .STEP(STAGE_STEPS), .SW(1)
	) u_div_invc (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s4), .num({1'b1, 32'd0}), .den(side_c_s4.c), .side_in(1'b0),
		.out_valid(dive_vld), .out_ovf(dive_ovf), .quot(dive_q), .side_out()
	);

	// Assemble all three rows of both matrices from the finished word.
	result_t            rows_c [3];
	logic signed [31:0] uoc;
	logic signed [31:0] invc;
	logic signed [31:0] c32;

	always_comb begin
		uoc  = sat_q(divd_ovf, divd_q, side_c_out.u[31]);
		invc = sat_q(dive_ovf, dive_q, 1'b0);
		c32  = $signed({8'd0, side_c_out.c});

		rows_c[0].row_index  = ROW_TOP;
		rows_c[0].right_col0 = Q_ONE;
		rows_c[0].right_col1 = Q_ONE;
		rows_c[0].right_col2 = Q_ONE;
		rows_c[0].left_col0  = qhalf(qadd(side_c_out.b2, uoc));
		rows_c[0].left_col1  = qneg(qhalf(qadd(side_c_out.b1u, invc)));
		rows_c[0].left_col2  = qhalf(side_c_out.b1);
		rows_c[0].last_row   = 1'b0;

		rows_c[1].row_index  = ROW_MID;
		rows_c[1].right_col0 = qsub(side_c_out.u, c32);
		rows_c[1].right_col1 = side_c_out.u;
		rows_c[1].right_col2 = qadd(side_c_out.u, c32);
		rows_c[1].left_col0  = qsub(Q_ONE, side_c_out.b2);
		rows_c[1].left_col1  = side_c_out.b1u;
		rows_c[1].left_col2  = qneg(side_c_out.b1);
		rows_c[1].last_row   = 1'b0;

		rows_c[2].row_index  = ROW_BOT;
		rows_c[2].right_col0 = qsub(side_c_out.h, side_c_out.uc);
		rows_c[2].right_col1 = side_c_out.uuh;
		rows_c[2].right_col2 = qadd(side_c_out.h, side_c_out.uc);
		rows_c[2].left_col0  = qhalf(qsub(side_c_out.b2, uoc));
		rows_c[2].left_col1  = qneg(qhalf(qsub(side_c_out.b1u, invc)));
		rows_c[2].left_col2  = qhalf(side_c_out.b1);
		rows_c[2].last_row   = 1'b1;
	end

	// Row buffer: holds one finished word and hands out its rows in order.
	// It takes the next word in the same cycle as its last row leaves.
	result_t    rows_q [3];
	logic       buf_vld_q;
	logic [1:0] row_q;

	assign fire     = result_valid && !result_stall;
	assign buf_free = !buf_vld_q || (fire && row_q == ROW_BOT);
	assign adv      = !divd_vld || buf_free;
	assign load     = divd_vld && buf_free;

	assign item_stall   = !adv;
	assign result_valid = buf_vld_q;
	assign result       = rows_q[row_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_vld_q <= 1'b0;
			row_q     <= ROW_TOP;
		end else if (load) begin
			buf_vld_q <= 1'b1;
			row_q     <= ROW_TOP;
		end else if (fire) begin
			if (row_q == ROW_BOT) begin
				buf_vld_q <= 1'b0;
				row_q     <= ROW_TOP;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rows_q <= rows_c;
		end
	end

	// The parallel units must stay in lockstep or their results get paired
	// with the wrong word.
	`ECEV_HOLDS(a_units_lockstep, (sq_vld == divb_vld) && (sq_vld == divc_vld) && (divd_vld == dive_vld), "parallel units out of step")
	// The row counter only walks through the three defined rows.
	`ECEV_IMPLIES(a_row_in_range, buf_vld_q, (row_q == ROW_TOP) || (row_q == ROW_MID) || (row_q == ROW_BOT), "row counter out of range")
	// A run of rows only ends after its last row has been taken.
	`ECEV_IMPLIES(a_run_ends_on_last, $fell(result_valid), $past(result.last_row) && !$past(result_stall), "result run ended early")

endmodule

[tb/euler_characteristic_eigenvectors_core_tb.sv]
`timescale 1ns / 1ps

module euler_characteristic_eigenvectors_core_tb
	import ecev_pkg::*;
;

	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam longint QONE = 64'sd65536;
	// Five stages plus three per ceil(31/4) divider steps.
	localparam int PIPE_DEPTH = 29;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [17:0] cfg_data = '0;

	// Gamma as the testbench believes the block holds it.
	logic [17:0] gamma_now = GAMMA_RESET;
	// Rows of R and L still owed by the block, oldest first.
	result_t     pending_rows[$];
	int          error_count = 0;
	int          rows_checked = 0;
	int          words_sent = 0;
	// Percent chance of an idle cycle on each side, and a forced stall stretch.
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_left = 0;

	euler_characteristic_eigenvectors_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Q16.16 helpers working on wide integers, saturating like the datapath.
	function automatic longint unsigned mag64(longint a);
		return (a < 0) ? longint'(-a) : a;
	endfunction

	function automatic longint clamp_q(longint x);
		if (x > QMAX) begin
			return QMAX;
		end
		if (x < QMIN) begin
			return QMIN;
		end
		return x;
	endfunction

	function automatic longint apply_sign(longint unsigned m, bit neg);
		if (neg) begin
			return (m > 64'd2147483648) ? QMIN : -longint'(m);
		end
		return (m > 64'd2147483647) ? QMAX : longint'(m);
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return apply_sign((mag64(a) * mag64(b)) >> 16, (a < 0) != (b < 0));
	endfunction

	function automatic longint fx_div(longint a, longint b);
		if (b == 0) begin
			return (a < 0) ? QMIN : QMAX;
		end
		return apply_sign((mag64(a) << 16) / mag64(b), (a < 0) != (b < 0));
	endfunction

	function automatic longint fx_half(longint a);
		return apply_sign(mag64(a) >> 1, a < 0);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Queue the three eigenvector rows that one primitive state produces.
	task automatic predict_eigen_rows(input item_t w);
		longint rho, u, p, g, gm1, c2, c, h, uu, uc, uoc, invc, b1, b2, b1u;
		longint unsigned m;
		longint ent[3][6];
		result_t r;
		rho = longint'(w.density);
		u = longint'(w.velocity_x);
		p = longint'(w.pressure);
		g = longint'(gamma_now);
		gm1 = (g > QONE) ? g - QONE : 1;
		if (rho < 1) begin
			rho = 1;
		end
		m = (mag64(p) * longint'(g)) / longint'(rho);
		if (p < 0 || m < 1) begin
			c2 = 1;
		end else if (m > 64'd2147483647) begin
			c2 = QMAX;
		end else begin
			c2 = longint'(m);
		end
		c = longint'(floor_sqrt(longint'(c2) << 16));
		uu = fx_mul(u, u);
		h = clamp_q(fx_div(c2, gm1) + fx_half(uu));
		uc = fx_mul(u, c);
		uoc = fx_div(u, c);
		invc = fx_div(QONE, c);
		b1 = fx_div(gm1, c2);
		b2 = fx_half(fx_mul(b1, uu));
		b1u = fx_mul(b1, u);
		ent[0] = '{QONE, QONE, QONE,
			fx_half(clamp_q(b2 + uoc)), clamp_q(-fx_half(clamp_q(b1u + invc))), fx_half(b1)};
		ent[1] = '{clamp_q(u - c), u, clamp_q(u + c),
			clamp_q(QONE - b2), b1u, clamp_q(-b1)};
		ent[2] = '{clamp_q(h - uc), fx_half(uu), clamp_q(h + uc),
			fx_half(clamp_q(b2 - uoc)), clamp_q(-fx_half(clamp_q(b1u - invc))), fx_half(b1)};
		for (int k = 0; k < 3; k++) begin
			r.row_index = (k == 0) ? ROW_TOP : (k == 1) ? ROW_MID : ROW_BOT;
			r.right_col0 = 32'(ent[k][0]);
			r.right_col1 = 32'(ent[k][1]);
			r.right_col2 = 32'(ent[k][2]);
			r.left_col0 = 32'(ent[k][3]);
			r.left_col1 = 32'(ent[k][4]);
			r.left_col2 = 32'(ent[k][5]);
			r.last_row = (k == 2);
			pending_rows = {pending_rows, r};
		end
	endtask

	// Offer one word, idling first when the current phase says so. Valid stays
	// high after acceptance so back-to-back words need only one assignment.
	task automatic send_word(input item_t w);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_eigen_rows(w);
		words_sent++;
	endtask

	// Let every expected row drain, then give the pipeline time to settle.
	task automatic drain_rows();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic write_gamma(input logic [17:0] v);
		drain_rows();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		gamma_now = v;
	endtask

	function automatic item_t make_word(int unsigned rho, int unsigned u, int unsigned p);
		item_t w;
		w.density = rho;
		w.velocity_x = u;
		w.pressure = p;
		return w;
	endfunction

	// Mostly physical states with random content, some raw 32-bit noise so
	// that every input bit toggles and the saturation paths get exercised.
	function automatic item_t random_word();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 70) begin
			return make_word($urandom_range(32'h0020_0000, 32'h0000_0100),
				32'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000),
				$urandom_range(32'h0100_0000, 32'h0000_0010));
		end
		if (sel < 85) begin
			return make_word($urandom_range(32'h0000_0040), $urandom,
				$urandom_range(32'h7FFF_FFFF));
		end
		return make_word($urandom, $urandom, $urandom);
	endfunction

	// Check every accepted result word against the oldest expected row.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_rows.size() == 0) begin
				$error("result word with no row expected");
				error_count++;
			end else begin
				want = pending_rows.pop_front();
				rows_checked++;
				if (result.row_index !== want.row_index) begin
					$error("row_index: expected %0d, got %0d", want.row_index,
						result.row_index);
					error_count++;
				end
				if (result.right_col0 !== want.right_col0) begin
					$error("right_col0: expected %0d, got %0d", want.right_col0,
						result.right_col0);
					error_count++;
				end
				if (result.right_col1 !== want.right_col1) begin
					$error("right_col1: expected %0d, got %0d", want.right_col1,
						result.right_col1);
					error_count++;
				end
				if (result.right_col2 !== want.right_col2) begin
					$error("right_col2: expected %0d, got %0d", want.right_col2,
						result.right_col2);
					error_count++;
				end
				if (result.left_col0 !== want.left_col0) begin
					$error("left_col0: expected %0d, got %0d", want.left_col0,
						result.left_col0);
					error_count++;
				end
				if (result.left_col1 !== want.left_col1) begin
					$error("left_col1: expected %0d, got %0d", want.left_col1,
						result.left_col1);
					error_count++;
				end
				if (result.left_col2 !== want.left_col2) begin
					$error("left_col2: expected %0d, got %0d", want.left_col2,
						result.left_col2);
					error_count++;
				end
				if (result.last_row !== want.last_row) begin
					$error("last_row: expected %0d, got %0d", want.last_row,
						result.last_row);
					error_count++;
				end
			end
		end
	end

	// Drive the result-side stall for the next cycle. A long hold-off wins over
	// the random stall of the current phase.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Corner states under the reset gamma: density floor, negative and zero
	// pressure, and the velocity and pressure extremes that saturate.
	task automatic test_corner_states();
		send_word(make_word(32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
		send_word(make_word(32'h0000_0000, 32'h0001_0000, 32'h0001_0000));
		send_word(make_word(32'h8000_0000, 32'h0002_0000, 32'h0001_0000));
		send_word(make_word(32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_0100));
		send_word(make_word(32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF));
		send_word(make_word(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000));
		send_word(make_word(32'h0001_0000, 32'h0001_0000, 32'h8000_0000));
		send_word(make_word(32'h0001_0000, 32'h0001_0000, 32'h0000_0000));
		send_word(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001));
		send_word(make_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		send_word(make_word(32'h0001_0000, 32'h8000_0000, 32'h0001_0000));
		send_word(make_word(32'h0001_0000, 32'hFFFF_FFFF, 32'h0001_0000));
		send_word(make_word(32'h0000_4000, 32'hFFFE_0000, 32'h0100_0000));
		send_word(make_word(32'h0010_0000, 32'h0300_0000, 32'h0000_0010));
	endtask

	// Gamma at and below one falls back to a tiny gamma - 1; the range ends and
	// an all-ones write cover every register bit.
	task automatic test_gamma_settings();
		logic [17:0] sweep[5];
		sweep = '{18'd65536, 18'd65537, 18'd196608, 18'd0, 18'h3FFFF};
		foreach (sweep[i]) begin
			write_gamma(sweep[i]);
			send_word(make_word(32'h0001_0000, 32'h0000_8000, 32'h0001_0000));
			send_word(make_word(32'h0000_1000, 32'hFFF0_0000, 32'h0040_0000));
		end
	endtask

	// Hold the result side off for a long stretch while words keep coming, so
	// the pipeline fills and pushes back on the input.
	task automatic test_backpressure();
		hold_left = 300;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (36) send_word(random_word());
		drain_rows();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n,
			input logic [17:0] g);
		write_gamma(g);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n) send_word(random_word());
		drain_rows();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_states();
		test_gamma_settings();
		test_backpressure();
		test_random_phase(0, 0, 80, GAMMA_RESET);
		test_random_phase(87, 0, 80, 18'd65537);
		test_random_phase(0, 87, 80, 18'd196608);
		test_random_phase(37, 37, 80, 18'($urandom_range(196608, 65537)));
		$display("Covered %0d state words and %0d eigenvector rows over several gamma values,",
			words_sent, rows_checked);
		$display("with idle, stall and long hold-off phases on both channels.");
		if (error_count == 0) begin
			$display("euler_characteristic_eigenvectors_core test passed");
		end else begin
			$display("euler_characteristic_eigenvectors_core test failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("euler_characteristic_eigenvectors_core test failed");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/ecev_pkg.sv
hdl/ecev_div.sv
hdl/ecev_sqrt.sv
hdl/euler_characteristic_eigenvectors_core.sv
tb/euler_characteristic_eigenvectors_core_tb.sv
